/* sv/kfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared KISS encoder constants: framing, escape, command bytes and step type.
// ----------------------------------------------------------------------------
package kfe_pkg;

   // frame delimiter and escape codes
   localparam logic [7:0] FEND  = 8'hC0;
   localparam logic [7:0] FESC  = 8'hDB;
   localparam logic [7:0] TFEND = 8'hDC;
   localparam logic [7:0] TFESC = 8'hDD;

   // command byte that follows the opening delimiter
   localparam logic [7:0] CMD_DATA = 8'h00;

   // width of the per-item step pointer
   localparam int STEP_W = 3;

   typedef logic [STEP_W-1:0] step_type;

endpackage

/* sv/kiss_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_frame_encoder
// Wraps payload bytes into KISS frames with FEND/FESC byte stuffing.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)  | tlast          | tuser
//  --------+-----+---------------------+----------------+---------------
//  req_    | in  | data_byte[7:0]      | last_byte      | -
//  rsp_    | out | out_byte[7:0]       | frame_end      | run_end
//  csr_    | in  | frame_type[7:0]     | -              | -
//
//  One result byte per cycle while rsp_ accepts; an input byte yields its data
//  byte, or FESC and TFEND/TFESC when escaped, led by FEND, the command byte
//  and frame_type when it opens a frame and followed by FEND when it closes it.
//  Results leave the single output register fed by the step pointer. The next
//  beat is taken in the same cycle as the last result of the current one loads.
//  Synchronous active-high reset clears the frame state and frame_type.
//  A stalled rsp_ side holds the output register and the pending input.
// ----------------------------------------------------------------------------
module kiss_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   // input beats
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   // result beats
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // frame_end
   output logic [0:0] rsp_tuser,   // [0] run_end
   // configuration
   input  logic       csr_we,
   input  logic [7:0] csr_wdata    // [7:0] frame_type
);

   // step codes within one input beat
   localparam kfe_pkg::step_type ST_HDR0 = 3'd0;
   localparam kfe_pkg::step_type ST_HDR1 = 3'd1;
   localparam kfe_pkg::step_type ST_HDR2 = 3'd2;
   localparam kfe_pkg::step_type ST_DATA = 3'd3;
   localparam kfe_pkg::step_type ST_ESC2 = 3'd4;
   localparam kfe_pkg::step_type ST_TAIL = 3'd5;

   logic [7:0]        frame_type_ff;
   logic              frame_open_ff, frame_open_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [7:0]        hold_data_ff, hold_data_in;
   logic              hold_last_ff, hold_last_in;
   kfe_pkg::step_type step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_fend_ff, rsp_fend_in;
   logic              rsp_rend_ff, rsp_rend_in;

   logic              req_accept;
   logic              out_load;
   logic              is_esc;
   logic              step_final;
   kfe_pkg::step_type step_next;
   logic [7:0]        step_byte;

   // byte needs an escape pair
   assign is_esc = (hold_data_ff == kfe_pkg::FEND) || (hold_data_ff == kfe_pkg::FESC);

   // output register can take a new byte
   assign out_load = hold_valid_ff && (!rsp_valid_ff || rsp_tready);

   // byte, successor and end-of-beat flag for the current step
   always_comb begin
      step_byte  = hold_data_ff;
      step_next  = ST_TAIL;
      step_final = 1'b0;
      case (step_ff)
         ST_HDR0: begin
            step_byte = kfe_pkg::FEND;
            step_next = ST_HDR1;
         end
         ST_HDR1: begin
            step_byte = kfe_pkg::CMD_DATA;
            step_next = ST_HDR2;
         end
         ST_HDR2: begin
            step_byte = frame_type_ff;
            step_next = ST_DATA;
         end
         ST_DATA: begin
            if (is_esc) begin
               step_byte = kfe_pkg::FESC;
               step_next = ST_ESC2;
            end else begin
               step_byte  = hold_data_ff;
               step_next  = ST_TAIL;
               step_final = !hold_last_ff;
            end
         end
         ST_ESC2: begin
            step_byte  = (hold_data_ff == kfe_pkg::FEND) ? kfe_pkg::TFEND : kfe_pkg::TFESC;
            step_next  = ST_TAIL;
            step_final = !hold_last_ff;
         end
         ST_TAIL: begin
            step_byte  = kfe_pkg::FEND;
            step_next  = ST_TAIL;
            step_final = 1'b1;
         end
         default: begin
            step_byte  = kfe_pkg::FEND;
            step_next  = ST_TAIL;
            step_final = 1'b1;
         end
      endcase
   end

   // take a new beat when idle or as the current one finishes
   assign req_tready = !hold_valid_ff || (out_load && step_final);
   assign req_accept = req_tvalid && req_tready;

   // input holding stage and frame state
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      hold_last_in  = hold_last_ff;
      step_in       = step_ff;
      frame_open_in = frame_open_ff;
      if (out_load) begin
         step_in = step_next;
         if (step_final) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         hold_valid_in = 1'b1;
         hold_data_in  = req_tdata;
         hold_last_in  = req_tlast;
         step_in       = frame_open_ff ? ST_DATA : ST_HDR0;
         frame_open_in = !req_tlast;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fend_in  = rsp_fend_ff;
      rsp_rend_in  = rsp_rend_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_byte;
         rsp_fend_in  = (step_ff == ST_TAIL);
         rsp_rend_in  = step_final;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_type_ff <= 8'h00;
         frame_open_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            frame_type_ff <= csr_wdata;
         end
         frame_open_ff <= frame_open_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_data_ff <= hold_data_in;
      hold_last_ff <= hold_last_in;
      step_ff      <= step_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_fend_ff  <= rsp_fend_in;
      rsp_rend_ff  <= rsp_rend_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_fend_ff;
   assign rsp_tuser[0] = rsp_rend_ff;

`ifndef SYNTHESIS
   // closing delimiter always ends the beat's results
   a_fend_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("frame end without run end");

   // second half of an escape pair follows an escape byte
   a_esc_pair: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && (step_ff == ST_ESC2) |-> rsp_data_ff == kfe_pkg::FESC)
      else $error("escape pair out of order");

   // header emitted only when no frame is open
   a_header_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> step_ff == ($past(frame_open_ff) ? ST_DATA : ST_HDR0))
      else $error("wrong start step for accepted beat");

   // frame end marks a delimiter byte
   a_fend_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == kfe_pkg::FEND)
      else $error("frame end on a non-delimiter byte");
`endif

endmodule
